### rtl/arc_pkg.sv
// Shared types and constants for the ARP resolver with pending queue.
// Used by every module under rtl/; depends on nothing.
`timescale 1ns / 1ps

package arc_pkg;

    localparam logic [47:0] BCAST_MAC  = 48'hFFFF_FFFF_FFFF;
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_ARP  = 16'h0806;
    localparam logic [15:0] OP_REQUEST = 16'd1;
    localparam logic [1:0]  OP_REQ_OUT = 2'd1;
    localparam logic [1:0]  OP_REP_OUT = 2'd2;

    localparam int IP_W   = 32;
    localparam int MAC_W  = 48;
    localparam int TIME_W = 22;
    localparam int TAG_W  = 8;

    typedef enum logic [1:0] {
        ACT_SEND = 2'd0,
        ACT_RECV = 2'd1,
        ACT_TICK = 2'd2,
        ACT_NONE = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        KIND_IPV4  = 3'd0,
        KIND_REQ   = 3'd1,
        KIND_REPLY = 3'd2,
        KIND_UP    = 3'd3,
        KIND_DROP  = 3'd4
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAP_LOOK,
        ST_HOLD_CHK,
        ST_SLOT_SCAN,
        ST_SLOT_WR,
        ST_QUEUE,
        ST_RECV,
        ST_RELEASE,
        ST_REPLY,
        ST_AGE,
        ST_FINISH
    } state_t;

    // Shared control broadcast to every cell of one table
    typedef struct packed {
        logic              age;
        logic [TIME_W-1:0] elapsed;
        logic [IP_W-1:0]   cmp_ip;
    } arc_ctl_t;

    // One result item, less the last-of-run flag
    typedef struct packed {
        kind_t             kind;
        logic [MAC_W-1:0]  dest_mac;
        logic [15:0]       ether_type;
        logic [TAG_W-1:0]  tag;
        logic [1:0]        arp_opcode;
        logic [MAC_W-1:0]  target_mac;
        logic [IP_W-1:0]   tgt_ip;
    } res_t;

endpackage

### rtl/arc_entry.sv
// One entry cell of the address map or holdoff table: key, data, time left.
// Compares its key, ages itself on a tick. Depends on arc_pkg.
`timescale 1ns / 1ps

module arc_entry
    import arc_pkg::*;
#(
    parameter int DATA_W = 48
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  arc_ctl_t          ctl,
    input  logic              wr_en,
    input  logic [IP_W-1:0]   wr_ip,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [TIME_W-1:0] wr_time,
    output logic              valid,
    output logic              hit,
    output logic [DATA_W-1:0] data,
    output logic [TIME_W-1:0] time_left
);

    logic              valid_reg;
    logic [IP_W-1:0]   ip_reg;
    logic [DATA_W-1:0] data_reg;
    logic [TIME_W-1:0] time_reg;

    // valid bit: set on write, cleared when a tick exhausts the time
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (wr_en) begin
            valid_reg <= 1'b1;
        end else if (ctl.age && valid_reg && time_reg <= ctl.elapsed) begin
            valid_reg <= 1'b0;
        end
    end

    // payload and time left
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ip_reg   <= wr_ip;
            data_reg <= wr_data;
            time_reg <= wr_time;
        end else if (ctl.age && valid_reg && time_reg > ctl.elapsed) begin
            time_reg <= time_reg - ctl.elapsed;
        end
    end

    assign valid     = valid_reg;
    assign hit       = valid_reg && (ip_reg == ctl.cmp_ip);
    assign data      = data_reg;
    assign time_left = time_reg;

endmodule

### rtl/arc_qcell.sv
// One slot of the packed wait queue. During a release pass every slot
// takes its upper neighbor; the tail slot takes the old head. Depends on arc_pkg.
`timescale 1ns / 1ps

module arc_qcell
    import arc_pkg::*;
(
    input  logic             aclk,
    input  logic             append,
    input  logic [IP_W-1:0]  in_ip,
    input  logic [TAG_W-1:0] in_tag,
    input  logic             shift,
    input  logic             tail_sel,
    input  logic [IP_W-1:0]  head_ip,
    input  logic [TAG_W-1:0] head_tag,
    input  logic [IP_W-1:0]  nb_ip,
    input  logic [TAG_W-1:0] nb_tag,
    output logic [IP_W-1:0]  ip,
    output logic [TAG_W-1:0] tag
);

    logic [IP_W-1:0]  ip_reg;
    logic [TAG_W-1:0] tag_reg;

    // append at the tail, or rotate one place toward the head
    always_ff @(posedge aclk) begin
        if (append) begin
            ip_reg  <= in_ip;
            tag_reg <= in_tag;
        end else if (shift) begin
            ip_reg  <= tail_sel ? head_ip  : nb_ip;
            tag_reg <= tail_sel ? head_tag : nb_tag;
        end
    end

    assign ip  = ip_reg;
    assign tag = tag_reg;

endmodule

### rtl/arp_resolver_with_pending_queue_top.sv
// Top level of the ARP resolver: address map, holdoff table, wait queue and
// the sequencer that walks them. Depends on arc_pkg, arc_entry, arc_qcell.
`timescale 1ns / 1ps

// One item is handled at a time. A send walks the map one entry per cycle while
// the result buffer can advance (it stalls when both result registers are full
// and m_tready is low); a miss adds a holdoff check and, when a request goes
// out, a slot scan of the holdoff table, a slot write and a queue step. An ARP
// receive scans the map for a slot, writes it, makes a release pass that visits
// each queued tag once, then checks for a reply. Each result transfer may
// stall when the downstream side holds m_tready low; one result is buffered so
// last_of_run is known when it leaves.
module arp_resolver_with_pending_queue_top
    import arc_pkg::*;
#(
    parameter int MAP_ENTRIES  = 16,
    parameter int HOLD_ENTRIES = 16,
    parameter int WAIT_DEPTH   = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // config write port
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [47:0]  cfg_data,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // [31:0] hop_ip, [39:32] dgram_tag, [87:40] frame_dst_mac,
    // [103:88] ether_type, [104] payload_ok, [120:105] arp_opcode,
    // [152:121] arp_sender_ip, [200:153] arp_sender_mac,
    // [232:201] arp_tpa, [254:233] elapsed_ms, [255] zero
    input  logic [255:0] s_tdata,
    input  logic [1:0]   s_tuser,   // [1:0] action
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // [47:0] dest_mac, [63:48] out_ether_type, [71:64] out_tag,
    // [73:72] out_arp_opcode, [121:74] out_target_mac,
    // [153:122] out_tpa, [159:154] zero
    output logic [159:0] m_tdata,
    output logic [2:0]   m_tuser,   // [2:0] out_kind
    output logic         m_tlast    // last_of_run
);

    localparam int MAP_IW  = (MAP_ENTRIES  > 1) ? $clog2(MAP_ENTRIES)  : 1;
    localparam int HOLD_IW = (HOLD_ENTRIES > 1) ? $clog2(HOLD_ENTRIES) : 1;
    localparam int SCAN_W  = (MAP_IW > HOLD_IW) ? MAP_IW : HOLD_IW;
    localparam int WAIT_CW = $clog2(WAIT_DEPTH + 1);
    localparam int WAIT_IW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;

    // configuration registers
    logic [47:0]       own_mac_reg;
    logic [31:0]       own_ip_reg;
    logic [TIME_W-1:0] ttl_reg;
    logic [TIME_W-1:0] cooldown_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_mac_reg  <= '0;
            own_ip_reg   <= '0;
            ttl_reg      <= TIME_W'(30000);
            cooldown_reg <= TIME_W'(5000);
        end else if (cfg_we) begin
            case (cfg_index)
                2'd0:    own_mac_reg  <= cfg_data;
                2'd1:    own_ip_reg   <= cfg_data[31:0];
                2'd2:    ttl_reg      <= cfg_data[TIME_W-1:0];
                default: cooldown_reg <= cfg_data[TIME_W-1:0];
            endcase
        end
    end

    // latched input item
    action_t          act_reg;
    logic [31:0]      nh_reg;
    logic [TAG_W-1:0] tag_reg;
    logic [47:0]      fdst_reg;
    logic [15:0]      et_reg;
    logic             pok_reg;
    logic [15:0]      op_reg;
    logic [31:0]      sip_reg;
    logic [47:0]      smac_reg;
    logic [31:0]      tip_reg;
    logic [TIME_W-1:0] el_reg;

    // sequencer state
    state_t              state_reg, state_next;
    logic [SCAN_W-1:0]   idx_reg, idx_next;
    logic                tbl_hold_reg, tbl_hold_next;
    logic                fm_v_reg, fm_v_next, ff_v_reg, ff_v_next, lt_v_reg, lt_v_next;
    logic [SCAN_W-1:0]   fm_reg, fm_next, ff_reg, ff_next, lt_reg, lt_next;
    logic [TIME_W-1:0]   lt_time_reg, lt_time_next;
    logic [WAIT_CW-1:0]  cnt_reg, cnt_next;
    logic [WAIT_CW-1:0]  rel_reg, rel_next;

    // result buffering
    res_t pend_reg;
    logic pend_v_reg;
    res_t out_reg;
    logic out_v_reg;
    logic out_last_reg;

    logic emit, fin, can_adv;
    res_t emit_res;

    // table cells
    arc_ctl_t map_ctl, hold_ctl;
    logic [MAP_ENTRIES-1:0]  map_wr, map_valid, map_hit;
    logic [47:0]             map_mac  [MAP_ENTRIES];
    logic [TIME_W-1:0]       map_time [MAP_ENTRIES];
    logic [HOLD_ENTRIES-1:0] hold_wr, hold_valid, hold_hit, hold_busy;
    logic [TIME_W-1:0]       hold_time [HOLD_ENTRIES];
    logic                    age_en;

    assign map_ctl.age     = age_en;
    assign map_ctl.elapsed = el_reg;
    assign map_ctl.cmp_ip  = (act_reg == ACT_SEND) ? nh_reg : sip_reg;
    assign hold_ctl.age     = age_en;
    assign hold_ctl.elapsed = el_reg;
    assign hold_ctl.cmp_ip  = nh_reg;

    genvar gi;
    generate
        for (gi = 0; gi < MAP_ENTRIES; gi++) begin : g_map
            arc_entry #(.DATA_W(48)) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctl       (map_ctl),
                .wr_en     (map_wr[gi]),
                .wr_ip     (sip_reg),
                .wr_data   (smac_reg),
                .wr_time   (ttl_reg),
                .valid     (map_valid[gi]),
                .hit       (map_hit[gi]),
                .data      (map_mac[gi]),
                .time_left (map_time[gi])
            );
        end
        for (gi = 0; gi < HOLD_ENTRIES; gi++) begin : g_hold
            logic unused_data;
            arc_entry #(.DATA_W(1)) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctl       (hold_ctl),
                .wr_en     (hold_wr[gi]),
                .wr_ip     (nh_reg),
                .wr_data   (1'b0),
                .wr_time   (cooldown_reg),
                .valid     (hold_valid[gi]),
                .hit       (hold_hit[gi]),
                .data      (unused_data),
                .time_left (hold_time[gi])
            );
            assign hold_busy[gi] = hold_hit[gi] && (hold_time[gi] != '0) && !unused_data;
        end
    endgenerate

    // wait queue chain
    logic [WAIT_DEPTH-1:0] q_append;
    logic                  q_shift;
    logic [WAIT_IW-1:0]    q_tail;
    logic [31:0]           q_ip  [WAIT_DEPTH];
    logic [TAG_W-1:0]      q_tag [WAIT_DEPTH];

    generate
        for (gi = 0; gi < WAIT_DEPTH; gi++) begin : g_wait
            logic [31:0]      nb_ip;
            logic [TAG_W-1:0] nb_tag;
            if (gi < WAIT_DEPTH - 1) begin : g_nb
                assign nb_ip  = q_ip[gi+1];
                assign nb_tag = q_tag[gi+1];
            end else begin : g_end
                assign nb_ip  = q_ip[0];
                assign nb_tag = q_tag[0];
            end
            arc_qcell u_cell (
                .aclk     (aclk),
                .append   (q_append[gi]),
                .in_ip    (nh_reg),
                .in_tag   (tag_reg),
                .shift    (q_shift),
                .tail_sel (q_tail == WAIT_IW'(gi)),
                .head_ip  (q_ip[0]),
                .head_tag (q_tag[0]),
                .nb_ip    (nb_ip),
                .nb_tag   (nb_tag),
                .ip       (q_ip[gi]),
                .tag      (q_tag[gi])
            );
        end
    endgenerate

    assign q_tail = (cnt_reg != '0) ? WAIT_IW'(cnt_reg - 1'b1) : '0;

    // current entry of the table being scanned
    logic              cur_v, cur_hit;
    logic [TIME_W-1:0] cur_time;
    logic [SCAN_W-1:0] scan_last;
    logic [SCAN_W-1:0] slot;
    logic              dst_ok;

    always_comb begin
        if (tbl_hold_reg) begin
            cur_v     = hold_valid[idx_reg[HOLD_IW-1:0]];
            cur_hit   = hold_hit[idx_reg[HOLD_IW-1:0]];
            cur_time  = hold_time[idx_reg[HOLD_IW-1:0]];
            scan_last = SCAN_W'(HOLD_ENTRIES - 1);
        end else begin
            cur_v     = map_valid[idx_reg[MAP_IW-1:0]];
            cur_hit   = map_hit[idx_reg[MAP_IW-1:0]];
            cur_time  = map_time[idx_reg[MAP_IW-1:0]];
            scan_last = SCAN_W'(MAP_ENTRIES - 1);
        end
        slot = fm_v_reg ? fm_reg : (ff_v_reg ? ff_reg : lt_reg);
    end

    assign dst_ok  = (fdst_reg == own_mac_reg) || (fdst_reg == BCAST_MAC);
    assign can_adv = !pend_v_reg || !out_v_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    // next state and datapath controls
    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        tbl_hold_next = tbl_hold_reg;
        fm_v_next = fm_v_reg; ff_v_next = ff_v_reg; lt_v_next = lt_v_reg;
        fm_next = fm_reg; ff_next = ff_reg; lt_next = lt_reg;
        lt_time_next = lt_time_reg;
        cnt_next  = cnt_reg;
        rel_next  = rel_reg;
        emit      = 1'b0;
        fin       = 1'b0;
        emit_res  = '0;
        map_wr    = '0;
        hold_wr   = '0;
        q_append  = '0;
        q_shift   = 1'b0;
        age_en    = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    idx_next = '0;
                    unique case (action_t'(s_tuser))
                        ACT_SEND: state_next = ST_MAP_LOOK;
                        ACT_RECV: state_next = ST_RECV;
                        ACT_TICK: state_next = ST_AGE;
                        default:  state_next = ST_FINISH;
                    endcase
                    tbl_hold_next = 1'b0;
                end
            end
            ST_MAP_LOOK: begin
                if (can_adv) begin
                    if (map_hit[idx_reg[MAP_IW-1:0]]) begin
                        emit = 1'b1;
                        emit_res.kind       = KIND_IPV4;
                        emit_res.dest_mac   = map_mac[idx_reg[MAP_IW-1:0]];
                        emit_res.ether_type = ETYPE_IPV4;
                        emit_res.tag        = tag_reg;
                        state_next = ST_FINISH;
                    end else if (idx_reg == SCAN_W'(MAP_ENTRIES - 1)) begin
                        state_next = ST_HOLD_CHK;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_HOLD_CHK: begin
                if (can_adv) begin
                    if (|hold_busy) begin
                        state_next = ST_QUEUE;
                    end else begin
                        emit = 1'b1;
                        emit_res.kind       = KIND_REQ;
                        emit_res.dest_mac   = BCAST_MAC;
                        emit_res.ether_type = ETYPE_ARP;
                        emit_res.arp_opcode = OP_REQ_OUT;
                        emit_res.tgt_ip     = nh_reg;
                        tbl_hold_next = 1'b1;
                        idx_next  = '0;
                        fm_v_next = 1'b0; ff_v_next = 1'b0; lt_v_next = 1'b0;
                        state_next = ST_SLOT_SCAN;
                    end
                end
            end
            ST_SLOT_SCAN: begin
                // first match, first free, least time left (lowest on tie)
                if (cur_hit && !fm_v_reg) begin
                    fm_v_next = 1'b1; fm_next = idx_reg;
                end
                if (!cur_v && !ff_v_reg) begin
                    ff_v_next = 1'b1; ff_next = idx_reg;
                end
                if (cur_v && (!lt_v_reg || cur_time < lt_time_reg)) begin
                    lt_v_next = 1'b1; lt_next = idx_reg; lt_time_next = cur_time;
                end
                if (idx_reg == scan_last) begin
                    state_next = ST_SLOT_WR;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_SLOT_WR: begin
                if (tbl_hold_reg) begin
                    hold_wr[slot[HOLD_IW-1:0]] = 1'b1;
                    state_next = ST_QUEUE;
                end else begin
                    map_wr[slot[MAP_IW-1:0]] = 1'b1;
                    rel_next   = cnt_reg;
                    state_next = ST_RELEASE;
                end
            end
            ST_QUEUE: begin
                if (can_adv) begin
                    if (cnt_reg < WAIT_CW'(WAIT_DEPTH)) begin
                        q_append[cnt_reg[WAIT_IW-1:0]] = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end else begin
                        emit = 1'b1;
                        emit_res.kind = KIND_DROP;
                        emit_res.tag  = tag_reg;
                    end
                    state_next = ST_FINISH;
                end
            end
            ST_RECV: begin
                if (can_adv) begin
                    state_next = ST_FINISH;
                    if (dst_ok && pok_reg) begin
                        if (et_reg == ETYPE_IPV4) begin
                            emit = 1'b1;
                            emit_res.kind       = KIND_UP;
                            emit_res.ether_type = ETYPE_IPV4;
                        end else if (et_reg == ETYPE_ARP) begin
                            idx_next  = '0;
                            fm_v_next = 1'b0; ff_v_next = 1'b0; lt_v_next = 1'b0;
                            state_next = ST_SLOT_SCAN;
                        end
                    end
                end
            end
            ST_RELEASE: begin
                // head leaves; kept tags rotate to the tail in order
                if (can_adv) begin
                    if (rel_reg == '0) begin
                        state_next = ST_REPLY;
                    end else begin
                        q_shift  = 1'b1;
                        rel_next = rel_reg - 1'b1;
                        if (q_ip[0] == sip_reg) begin
                            emit = 1'b1;
                            emit_res.kind       = KIND_IPV4;
                            emit_res.dest_mac   = smac_reg;
                            emit_res.ether_type = ETYPE_IPV4;
                            emit_res.tag        = q_tag[0];
                            cnt_next = cnt_reg - 1'b1;
                        end
                    end
                end
            end
            ST_REPLY: begin
                if (can_adv) begin
                    if (op_reg == OP_REQUEST && tip_reg == own_ip_reg) begin
                        emit = 1'b1;
                        emit_res.kind       = KIND_REPLY;
                        emit_res.dest_mac   = smac_reg;
                        emit_res.ether_type = ETYPE_ARP;
                        emit_res.arp_opcode = OP_REP_OUT;
                        emit_res.target_mac = smac_reg;
                        emit_res.tgt_ip     = sip_reg;
                    end
                    state_next = ST_FINISH;
                end
            end
            ST_AGE: begin
                age_en     = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (can_adv) begin
                    fin        = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            pend_v_reg   <= 1'b0;
            out_v_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (out_v_reg && m_tready) begin
                out_v_reg <= 1'b0;
            end
            if (emit) begin
                pend_v_reg <= 1'b1;
                if (pend_v_reg) begin
                    out_v_reg <= 1'b1;
                end
            end else if (fin && pend_v_reg) begin
                pend_v_reg <= 1'b0;
                out_v_reg  <= 1'b1;
            end
        end
    end

    // scan trackers, counters and result payload
    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        tbl_hold_reg <= tbl_hold_next;
        fm_v_reg <= fm_v_next; ff_v_reg <= ff_v_next; lt_v_reg <= lt_v_next;
        fm_reg   <= fm_next;   ff_reg   <= ff_next;   lt_reg   <= lt_next;
        lt_time_reg <= lt_time_next;
        rel_reg     <= rel_next;
        if (emit) begin
            pend_reg <= emit_res;
            if (pend_v_reg) begin
                out_reg      <= pend_reg;
                out_last_reg <= 1'b0;
            end
        end else if (fin && pend_v_reg) begin
            out_reg      <= pend_reg;
            out_last_reg <= 1'b1;
        end
    end

    // input capture
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            act_reg  <= action_t'(s_tuser);
            nh_reg   <= s_tdata[31:0];
            tag_reg  <= s_tdata[39:32];
            fdst_reg <= s_tdata[87:40];
            et_reg   <= s_tdata[103:88];
            pok_reg  <= s_tdata[104];
            op_reg   <= s_tdata[120:105];
            sip_reg  <= s_tdata[152:121];
            smac_reg <= s_tdata[200:153];
            tip_reg  <= s_tdata[232:201];
            el_reg   <= s_tdata[254:233];
        end
    end

    // result port
    assign m_tvalid = out_v_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {6'd0, out_reg.tgt_ip, out_reg.target_mac, out_reg.arp_opcode,
                       out_reg.tag, out_reg.ether_type, out_reg.dest_mac};

endmodule
